/* hdl/sobb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sobb_pkg;

   // Shape kind codes carried on the kind fields.
   localparam logic KIND_CIRCLE = 1'b0;
   localparam logic KIND_RECT   = 1'b1;

   // The label is a fixed 16-bit running identifier.
   localparam int LABEL_BITS = 16;

   // Control group that travels with one transaction from the selection
   // stage into the squared-distance unit.
   typedef struct packed {
      logic valid;      // stage holds a live transaction
      logic pair_rect;  // both shapes are rectangles
      logic rect_hit;   // rectangle extents touch or intersect
      logic in_reach;   // both axis distances pass the coarse bound
      logic strict;     // circle pair: distance must be strictly below
   } sobb_ctl_type;

endpackage

`default_nettype wire

/* hdl/sobb_dist.sv */
`timescale 1ns / 1ps
`default_nettype none

module sobb_dist #(
   parameter int COORD_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  sobb_pkg::sobb_ctl_type    ctl_in,
   input  logic [COORD_BITS-1:0]     dx,
   input  logic [COORD_BITS-1:0]     dy,
   input  logic [COORD_BITS-1:0]     lim,
   output logic                      valid,
   output logic                      hit
);
   import sobb_pkg::*;

   localparam int SQ_BITS  = 2 * COORD_BITS;
   localparam int SUM_BITS = SQ_BITS + 1;

   sobb_ctl_type        ctl_ff;
   logic [SQ_BITS-1:0]  dx2_ff, dx2_in;
   logic [SQ_BITS-1:0]  dy2_ff, dy2_in;
   logic [SQ_BITS-1:0]  t2_ff, t2_in;
   logic [SUM_BITS-1:0] sum;
   logic [SUM_BITS-1:0] t2_ext;
   logic                dist_ok;

   // Three squarers, each registered before the sum.
   always_comb begin
      dx2_in = SQ_BITS'(dx) * SQ_BITS'(dx);
      dy2_in = SQ_BITS'(dy) * SQ_BITS'(dy);
      t2_in  = SQ_BITS'(lim) * SQ_BITS'(lim);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      dx2_ff <= dx2_in;
      dy2_ff <= dy2_in;
      t2_ff  <= t2_in;
   end

   // Sum of squares against the squared limit; touching counts only for
   // a mixed pair.
   always_comb begin
      sum     = {1'b0, dx2_ff} + {1'b0, dy2_ff};
      t2_ext  = {1'b0, t2_ff};
      dist_ok = ctl_ff.strict ? (sum < t2_ext) : (sum <= t2_ext);
   end

   assign valid = ctl_ff.valid;
   assign hit   = ctl_ff.valid &
                  (ctl_ff.pair_rect ? ctl_ff.rect_hit : (ctl_ff.in_reach & dist_ok));

`ifndef ASSERT_OFF
   // A rectangle pair takes its verdict straight from the extent compare.
   a_rect_pass: assert property (@(posedge clock) disable iff (reset)
      ctl_in.valid && ctl_in.pair_rect |=> hit == $past(ctl_in.rect_hit))
      else $error("rectangle verdict lost in distance stage");

   // Two circles of zero total radius can never overlap.
   a_zero_radius: assert property (@(posedge clock) disable iff (reset)
      hit && ctl_ff.strict |-> t2_ff != '0)
      else $error("zero-radius circle pair reported overlap");

   // A circle center on the rectangle always counts as a hit.
   a_touch: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.valid && !ctl_ff.pair_rect && !ctl_ff.strict && ctl_ff.in_reach &&
      dx2_ff == '0 && dy2_ff == '0 |-> hit)
      else $error("contained circle center not reported as overlap");
`endif

endmodule

`default_nettype wire

/* hdl/shape_overlap_bounding_box.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// request   in         start, busy          req_a_*, req_b_*, req_label
// response  out        rsp_valid (strobe)   rsp_overlap, rsp_box_*
//
// One transaction can be taken in every clock cycle; busy is high only
// during reset and the cycle after it.
// The result strobes on rsp_valid once the transaction has passed the registered
// stages in order: extents, selection, squaring, and the output register.
// The squarers set the depth of the third stage.
// Reset is synchronous and active high and empties every stage.
// The receiver cannot stall, so the pipeline never holds.

module shape_overlap_bounding_box #(
   parameter int COORD_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_a_kind,
   input  logic signed [COORD_BITS-1:0]      req_a_x,
   input  logic signed [COORD_BITS-1:0]      req_a_y,
   input  logic [COORD_BITS-2:0]             req_a_size_w,
   input  logic [COORD_BITS-2:0]             req_a_size_h,
   input  logic                              req_b_kind,
   input  logic signed [COORD_BITS-1:0]      req_b_x,
   input  logic signed [COORD_BITS-1:0]      req_b_y,
   input  logic [COORD_BITS-2:0]             req_b_size_w,
   input  logic [COORD_BITS-2:0]             req_b_size_h,
   input  logic [sobb_pkg::LABEL_BITS-1:0]   req_label,
   output logic                              rsp_valid,
   output logic                              rsp_overlap,
   output logic signed [COORD_BITS:0]        rsp_box_x,
   output logic signed [COORD_BITS:0]        rsp_box_y,
   output logic [COORD_BITS+1:0]             rsp_box_w,
   output logic [COORD_BITS+1:0]             rsp_box_h,
   output logic [sobb_pkg::LABEL_BITS-1:0]   rsp_box_label
);
   import sobb_pkg::*;

   localparam int C = COORD_BITS;
   localparam int S = COORD_BITS - 1;
   localparam int P = COORD_BITS + 1;
   localparam int L = COORD_BITS + 2;

   // ---------------------------------------------------------------
   // Accept control.
   logic busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy = busy_ff;

   // ---------------------------------------------------------------
   // Stage 1: extents of both shapes and the radius sum.
   logic                    kind_w [2];
   logic signed [C-1:0]     x_w    [2];
   logic signed [C-1:0]     y_w    [2];
   logic [S-1:0]            w_w    [2];
   logic [S-1:0]            h_w    [2];

   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_kind_ff [2];
   logic signed [C-1:0]     s1_cx_ff   [2];
   logic signed [C-1:0]     s1_cy_ff   [2];
   logic [S-1:0]            s1_rad_ff  [2];
   logic signed [P-1:0]     s1_lx_ff [2], s1_lx_in [2];
   logic signed [P-1:0]     s1_ly_ff [2], s1_ly_in [2];
   logic signed [P-1:0]     s1_hx_ff [2], s1_hx_in [2];
   logic signed [P-1:0]     s1_hy_ff [2], s1_hy_in [2];
   logic [C-1:0]            s1_rs_ff, s1_rs_in;
   logic [LABEL_BITS-1:0]   s1_label_ff;

   always_comb begin
      kind_w[0] = req_a_kind;
      x_w[0]    = req_a_x;
      y_w[0]    = req_a_y;
      w_w[0]    = req_a_size_w;
      h_w[0]    = req_a_size_h;
      kind_w[1] = req_b_kind;
      x_w[1]    = req_b_x;
      y_w[1]    = req_b_y;
      w_w[1]    = req_b_size_w;
      h_w[1]    = req_b_size_h;
   end

   // A circle spans center plus and minus radius; a rectangle spans its
   // corner plus width and height.
   always_comb begin
      logic signed [P-1:0] xp;
      logic signed [P-1:0] yp;
      logic signed [P-1:0] wp;
      logic signed [P-1:0] hp;
      for (int i = 0; i < 2; i++) begin
         xp = {x_w[i][C-1], x_w[i]};
         yp = {y_w[i][C-1], y_w[i]};
         wp = {2'b00, w_w[i]};
         hp = {2'b00, h_w[i]};
         if (kind_w[i] == KIND_RECT) begin
            s1_lx_in[i] = xp;
            s1_ly_in[i] = yp;
            s1_hx_in[i] = xp + wp;
            s1_hy_in[i] = yp + hp;
         end else begin
            s1_lx_in[i] = xp - wp;
            s1_ly_in[i] = yp - wp;
            s1_hx_in[i] = xp + wp;
            s1_hy_in[i] = yp + wp;
         end
      end
      s1_rs_in    = {1'b0, req_a_size_w} + {1'b0, req_b_size_w};
      s1_valid_in = start & ~busy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 2; i++) begin
         s1_kind_ff[i] <= kind_w[i];
         s1_cx_ff[i]   <= x_w[i];
         s1_cy_ff[i]   <= y_w[i];
         s1_rad_ff[i]  <= w_w[i];
         s1_lx_ff[i]   <= s1_lx_in[i];
         s1_ly_ff[i]   <= s1_ly_in[i];
         s1_hx_ff[i]   <= s1_hx_in[i];
         s1_hy_ff[i]   <= s1_hy_in[i];
      end
      s1_rs_ff    <= s1_rs_in;
      s1_label_ff <= req_label;
   end

   // ---------------------------------------------------------------
   // Stage 2: pick the distance test, axis distances and the union box.
   sobb_ctl_type            s2_ctl_ff, s2_ctl_in;
   logic [C-1:0]            s2_dx_ff, s2_dx_in;
   logic [C-1:0]            s2_dy_ff, s2_dy_in;
   logic [C-1:0]            s2_lim_ff, s2_lim_in;
   logic signed [P-1:0]     s2_lx_ff, s2_lx_in;
   logic signed [P-1:0]     s2_ly_ff, s2_ly_in;
   logic signed [P-1:0]     s2_hx_ff, s2_hx_in;
   logic signed [P-1:0]     s2_hy_ff, s2_hy_in;
   logic [LABEL_BITS-1:0]   s2_label_ff;

   always_comb begin
      logic signed [P-1:0] ddx;
      logic signed [P-1:0] ddy;
      logic signed [P-1:0] adx;
      logic signed [P-1:0] ady;
      logic signed [P-1:0] ccx;
      logic signed [P-1:0] ccy;
      logic signed [P-1:0] gx;
      logic signed [P-1:0] gy;
      logic [C-1:0]        rad;
      logic                both_rect;
      logic                both_circ;
      logic                ci;
      logic                qi;

      both_rect = (s1_kind_ff[0] == KIND_RECT) && (s1_kind_ff[1] == KIND_RECT);
      both_circ = (s1_kind_ff[0] == KIND_CIRCLE) && (s1_kind_ff[1] == KIND_CIRCLE);
      // In a mixed pair, ci points at the circle and qi at the rectangle.
      ci = (s1_kind_ff[0] == KIND_RECT);
      qi = ~ci;

      // Circle pair: absolute center differences.
      ddx = {s1_cx_ff[0][C-1], s1_cx_ff[0]} - {s1_cx_ff[1][C-1], s1_cx_ff[1]};
      ddy = {s1_cy_ff[0][C-1], s1_cy_ff[0]} - {s1_cy_ff[1][C-1], s1_cy_ff[1]};
      adx = ddx[P-1] ? -ddx : ddx;
      ady = ddy[P-1] ? -ddy : ddy;

      // Mixed pair: gap from the circle center to the rectangle on each axis.
      ccx = {s1_cx_ff[ci][C-1], s1_cx_ff[ci]};
      ccy = {s1_cy_ff[ci][C-1], s1_cy_ff[ci]};
      if (ccx < s1_lx_ff[qi]) begin
         gx = s1_lx_ff[qi] - ccx;
      end else if (ccx > s1_hx_ff[qi]) begin
         gx = ccx - s1_hx_ff[qi];
      end else begin
         gx = '0;
      end
      if (ccy < s1_ly_ff[qi]) begin
         gy = s1_ly_ff[qi] - ccy;
      end else if (ccy > s1_hy_ff[qi]) begin
         gy = ccy - s1_hy_ff[qi];
      end else begin
         gy = '0;
      end
      rad = {1'b0, s1_rad_ff[ci]};

      s2_ctl_in.valid     = s1_valid_ff;
      s2_ctl_in.pair_rect = both_rect;
      s2_ctl_in.rect_hit  = (s1_hx_ff[0] >= s1_lx_ff[1]) && (s1_hx_ff[1] >= s1_lx_ff[0]) &&
                            (s1_hy_ff[0] >= s1_ly_ff[1]) && (s1_hy_ff[1] >= s1_ly_ff[0]);
      s2_ctl_in.strict    = both_circ;
      if (both_circ) begin
         s2_dx_in           = adx[C-1:0];
         s2_dy_in           = ady[C-1:0];
         s2_lim_in          = s1_rs_ff;
         s2_ctl_in.in_reach = (adx[C-1:0] < s1_rs_ff) && (ady[C-1:0] < s1_rs_ff);
      end else begin
         s2_dx_in           = gx[C-1:0];
         s2_dy_in           = gy[C-1:0];
         s2_lim_in          = rad;
         s2_ctl_in.in_reach = (gx[C-1:0] <= rad) && (gy[C-1:0] <= rad);
      end

      // Union bounding box.
      s2_lx_in = (s1_lx_ff[0] < s1_lx_ff[1]) ? s1_lx_ff[0] : s1_lx_ff[1];
      s2_ly_in = (s1_ly_ff[0] < s1_ly_ff[1]) ? s1_ly_ff[0] : s1_ly_ff[1];
      s2_hx_in = (s1_hx_ff[0] > s1_hx_ff[1]) ? s1_hx_ff[0] : s1_hx_ff[1];
      s2_hy_in = (s1_hy_ff[0] > s1_hy_ff[1]) ? s1_hy_ff[0] : s1_hy_ff[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else begin
         s2_ctl_ff <= s2_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_dx_ff    <= s2_dx_in;
      s2_dy_ff    <= s2_dy_in;
      s2_lim_ff   <= s2_lim_in;
      s2_lx_ff    <= s2_lx_in;
      s2_ly_ff    <= s2_ly_in;
      s2_hx_ff    <= s2_hx_in;
      s2_hy_ff    <= s2_hy_in;
      s2_label_ff <= s1_label_ff;
   end

   // ---------------------------------------------------------------
   // Stage 3: squares in the distance unit, box size and label in parallel.
   logic                    dist_valid;
   logic                    dist_hit;
   logic signed [P-1:0]     s3_box_x_ff;
   logic signed [P-1:0]     s3_box_y_ff;
   logic [L-1:0]            s3_box_w_ff, s3_box_w_in;
   logic [L-1:0]            s3_box_h_ff, s3_box_h_in;
   logic [LABEL_BITS-1:0]   s3_label_ff, s3_label_in;

   sobb_dist #(
      .COORD_BITS (COORD_BITS)
   ) u_dist (
      .clock  (clock),
      .reset  (reset),
      .ctl_in (s2_ctl_ff),
      .dx     (s2_dx_ff),
      .dy     (s2_dy_ff),
      .lim    (s2_lim_ff),
      .valid  (dist_valid),
      .hit    (dist_hit)
   );

   always_comb begin
      s3_box_w_in = {s2_hx_ff[P-1], s2_hx_ff} - {s2_lx_ff[P-1], s2_lx_ff};
      s3_box_h_in = {s2_hy_ff[P-1], s2_hy_ff} - {s2_ly_ff[P-1], s2_ly_ff};
      s3_label_in = s2_label_ff + LABEL_BITS'(1);
   end

   always_ff @(posedge clock) begin
      s3_box_x_ff <= s2_lx_ff;
      s3_box_y_ff <= s2_ly_ff;
      s3_box_w_ff <= s3_box_w_in;
      s3_box_h_ff <= s3_box_h_in;
      s3_label_ff <= s3_label_in;
   end

   // ---------------------------------------------------------------
   // Output register: box fields read zero when the shapes are apart.
   logic                    rsp_valid_ff;
   logic                    rsp_overlap_ff;
   logic signed [P-1:0]     rsp_box_x_ff, rsp_box_x_in;
   logic signed [P-1:0]     rsp_box_y_ff, rsp_box_y_in;
   logic [L-1:0]            rsp_box_w_ff, rsp_box_w_in;
   logic [L-1:0]            rsp_box_h_ff, rsp_box_h_in;
   logic [LABEL_BITS-1:0]   rsp_box_label_ff, rsp_box_label_in;

   always_comb begin
      rsp_box_x_in     = dist_hit ? s3_box_x_ff : '0;
      rsp_box_y_in     = dist_hit ? s3_box_y_ff : '0;
      rsp_box_w_in     = dist_hit ? s3_box_w_ff : '0;
      rsp_box_h_in     = dist_hit ? s3_box_h_ff : '0;
      rsp_box_label_in = dist_hit ? s3_label_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         rsp_overlap_ff   <= 1'b0;
         rsp_box_x_ff     <= '0;
         rsp_box_y_ff     <= '0;
         rsp_box_w_ff     <= '0;
         rsp_box_h_ff     <= '0;
         rsp_box_label_ff <= '0;
      end else begin
         rsp_valid_ff     <= dist_valid;
         rsp_overlap_ff   <= dist_hit;
         rsp_box_x_ff     <= rsp_box_x_in;
         rsp_box_y_ff     <= rsp_box_y_in;
         rsp_box_w_ff     <= rsp_box_w_in;
         rsp_box_h_ff     <= rsp_box_h_in;
         rsp_box_label_ff <= rsp_box_label_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_overlap   = rsp_overlap_ff;
   assign rsp_box_x     = rsp_box_x_ff;
   assign rsp_box_y     = rsp_box_y_ff;
   assign rsp_box_w     = rsp_box_w_ff;
   assign rsp_box_h     = rsp_box_h_ff;
   assign rsp_box_label = rsp_box_label_ff;

`ifndef ASSERT_OFF
   // Every accepted transaction produces its strobe on rsp_valid.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##4 rsp_valid)
      else $error("accepted transaction did not complete in four cycles");

   // An overlap is only reported on a strobed result.
   a_overlap_strobed: assert property (@(posedge clock) disable iff (reset)
      rsp_overlap |-> rsp_valid)
      else $error("overlap reported without result strobe");

   // Results with no overlap carry an all-zero box.
   a_zero_box: assert property (@(posedge clock) disable iff (reset)
      !rsp_overlap |-> rsp_box_x == '0 && rsp_box_y == '0 && rsp_box_w == '0 &&
                       rsp_box_h == '0 && rsp_box_label == '0)
      else $error("box fields not cleared for a miss");

   // The box label is the request label plus one, kept aligned with the data.
   a_label: assert property (@(posedge clock) disable iff (reset)
      rsp_overlap |-> rsp_box_label == LABEL_BITS'($past(req_label, 4) + LABEL_BITS'(1)))
      else $error("box label out of step with its request");
`endif

endmodule

`default_nettype wire
